FILE: rtl/i128_pkg.sv
// Shared types and constants for the 128-bit arithmetic unit.
package i128_pkg;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SADD = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_CLZ  = 3'd5,
    OP_CMP  = 3'd6,
    OP_NEG  = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_RUN  = 2'd1,
    ST_DONE = 2'd2
  } state_e;

  localparam logic [1:0] OrdLess    = 2'd0;
  localparam logic [1:0] OrdEqual   = 2'd1;
  localparam logic [1:0] OrdGreater = 2'd2;

  // Control from the sequencer to the serial datapath.
  typedef struct packed {
    logic load;
    logic step;
  } ctrl_t;

endpackage

FILE: rtl/i128_dp.sv
// Bit-serial datapath: add/sub/compare/negate, shift-add multiply, restoring divide, clz.
module i128_dp (
  input  logic                  clk_i,
  input  i128_pkg::ctrl_t       ctrl_i,
  input  logic [2:0]            op_i,
  input  logic [127:0]          a_i,
  input  logic [127:0]          b_i,
  output logic [127:0]          value_o,
  output logic                  flag_o,
  output logic [1:0]            order_o
);

  // Operand shift registers and result accumulators
  logic [127:0] a_q, a_d, b_q, b_d, r_q, r_d, m_q, m_d;
  logic [127:0] rem_q, rem_d;
  logic         c_q, c_d, f_q, f_d, z_q, z_d, gt_q, gt_d, lt_q, lt_d, seen_q, seen_d;
  logic         sa_q, sa_d, sb_q, sb_d;
  logic [2:0]   op_q, op_d;
  logic [7:0]   clz_q, clz_d;

  logic abit, bbit, bop, sbit, cout;
  logic [128:0] sh;
  logic [128:0] diff;
  logic [128:0] mac;

  always_comb begin
    a_d = a_q; b_d = b_q; r_d = r_q; m_d = m_q; rem_d = rem_q;
    c_d = c_q; f_d = f_q; z_d = z_q; gt_d = gt_q; lt_d = lt_q; seen_d = seen_q;
    sa_d = sa_q; sb_d = sb_q; op_d = op_q; clz_d = clz_q;
    abit = a_q[0];
    bbit = b_q[0];
    bop = 1'b0; sbit = 1'b0; cout = 1'b0;
    sh = '0; diff = '0; mac = '0;
    if (ctrl_i.load) begin
      op_d = op_i;
      a_d = a_i;
      b_d = b_i;
      r_d = '0;
      m_d = '0;
      rem_d = '0;
      seen_d = 1'b0;
      clz_d = '0;
      gt_d = 1'b0; lt_d = 1'b0;
      z_d = (b_i == '0);
      f_d = 1'b0;
      sa_d = a_i[127];
      // Subtract and negate enter with carry one
      c_d = (op_i == i128_pkg::OP_SUB) || (op_i == i128_pkg::OP_NEG);
      // Sign of -B: the carry of the increment reaches the top only when B's low bits are zero
      if (op_i == i128_pkg::OP_SUB) sb_d = ~b_i[127] ^ (b_i[126:0] == '0);
      else sb_d = b_i[127];
      if (op_i == i128_pkg::OP_NEG) sb_d = 1'b0;
    end else if (ctrl_i.step) begin
      unique case (i128_pkg::op_e'(op_q))
        i128_pkg::OP_ADD, i128_pkg::OP_SADD, i128_pkg::OP_SUB, i128_pkg::OP_NEG: begin
          // Ripple one bit per cycle, LSB first
          if (op_q == i128_pkg::OP_SUB) bop = ~bbit;
          else if (op_q == i128_pkg::OP_NEG) bop = 1'b0;
          else bop = bbit;
          if (op_q == i128_pkg::OP_NEG) abit = ~a_q[0];
          {cout, sbit} = {1'b0, abit} + {1'b0, bop} + {1'b0, c_q};
          c_d = cout;
          r_d = {sbit, r_q[127:1]};
          a_d = a_q >> 1;
          b_d = b_q >> 1;
        end
        i128_pkg::OP_CMP: begin
          // LSB first: later (higher) differing bits override
          if (abit & ~bbit) begin gt_d = 1'b1; lt_d = 1'b0; end
          else if (~abit & bbit) begin lt_d = 1'b1; gt_d = 1'b0; end
          a_d = a_q >> 1;
          b_d = b_q >> 1;
        end
        i128_pkg::OP_CLZ: begin
          // MSB first; count until the first one
          if (a_q[127]) seen_d = 1'b1;
          else if (!seen_q) clz_d = clz_q + 8'd1;
          a_d = a_q << 1;
        end
        i128_pkg::OP_MUL: begin
          // Shift-add on B's bits, MSB first; track bits lost past 128
          mac = {1'b0, m_q[126:0], 1'b0};
          if (m_q[127]) f_d = 1'b1;
          if (b_q[127]) begin
            mac = mac + {1'b0, a_q};
          end
          if (mac[128]) f_d = 1'b1;
          m_d = mac[127:0];
          b_d = b_q << 1;
          if (b_q[127] && m_q[127]) f_d = 1'b1;
        end
        default: begin
          // Restoring divide, one quotient bit per cycle
          sh = {rem_q, a_q[127]};
          diff = sh - {1'b0, b_q};
          a_d = a_q << 1;
          if (z_q) begin
            if (a_q[127]) seen_d = 1'b1;
            r_d = {r_q[126:0], seen_q | a_q[127]};
          end else if (!diff[128]) begin
            rem_d = diff[127:0];
            r_d = {r_q[126:0], 1'b1};
          end else begin
            rem_d = sh[127:0];
            r_d = {r_q[126:0], 1'b0};
          end
        end
      endcase
    end
  end

  // Advance the serial registers
  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; r_q <= r_d; m_q <= m_d; rem_q <= rem_d;
    c_q <= c_d; f_q <= f_d; z_q <= z_d; gt_q <= gt_d; lt_q <= lt_d; seen_q <= seen_d;
    sa_q <= sa_d; sb_q <= sb_d; op_q <= op_d; clz_q <= clz_d;
  end

  // Select the result
  always_comb begin
    value_o = '0;
    flag_o = 1'b0;
    order_o = i128_pkg::OrdLess;
    case (i128_pkg::op_e'(op_q))
      i128_pkg::OP_ADD: begin value_o = r_q; flag_o = c_q; end
      i128_pkg::OP_SADD, i128_pkg::OP_SUB: begin
        value_o = r_q;
        flag_o = (sa_q == sb_q) && (sa_q != r_q[127]);
      end
      i128_pkg::OP_NEG: begin
        value_o = r_q;
        flag_o = (r_q[127] == 1'b1) && (r_q[126:0] == '0);
      end
      i128_pkg::OP_MUL: begin value_o = m_q; flag_o = f_q; end
      i128_pkg::OP_DIV: begin value_o = r_q; flag_o = z_q; end
      i128_pkg::OP_CLZ: value_o = {120'd0, clz_q};
      default: order_o = gt_q ? i128_pkg::OrdGreater :
                         (lt_q ? i128_pkg::OrdLess : i128_pkg::OrdEqual);
    endcase
  end

endmodule

FILE: rtl/i128_seq.sv
// Sequencer: loads an item, counts 128 serial steps, holds the result for the sink.
module i128_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output i128_pkg::ctrl_t ctrl_o
);

  i128_pkg::state_e state_q, state_d;
  logic [7:0] cnt_q, cnt_d;

  // Next state
  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    unique case (state_q)
      i128_pkg::ST_IDLE: if (in_valid_i) begin state_d = i128_pkg::ST_RUN; cnt_d = '0; end
      i128_pkg::ST_RUN: begin
        cnt_d = cnt_q + 8'd1;
        if (cnt_q == 8'd127) state_d = i128_pkg::ST_DONE;
      end
      i128_pkg::ST_DONE: if (out_ready_i) state_d = i128_pkg::ST_IDLE;
      default: state_d = i128_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o = (state_q == i128_pkg::ST_IDLE);
    out_valid_o = (state_q == i128_pkg::ST_DONE);
    ctrl_o.load = (state_q == i128_pkg::ST_IDLE) && in_valid_i;
    ctrl_o.step = (state_q == i128_pkg::ST_RUN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= i128_pkg::ST_IDLE;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: rtl/int128_arith_unit.sv
// Top level of the 128-bit bit-serial integer arithmetic unit.
// One request on the slave stream carries opcode and operands A and B; one
// result leaves on the master stream per request.
// s_axis_tdata: opcode[2:0], a_hi, a_lo, b_hi, b_lo (packed from bit 0).
// m_axis_tdata: value_hi, value_lo, flag, order (packed from bit 0).
// Every opcode runs through 128 serial steps, one operand bit per cycle:
// the request is loaded at the edge that accepts it, the steps run at the
// edges that follow, and the result is offered right after the last step.
// The unit returns to idle as the result leaves, so a new request is taken
// only after the previous result has left, and an output stall delays it.
// The multiply is a shift-add over B's bits; the divide is restoring, one
// quotient bit per cycle. Only one request is in flight.
// Reset empties the unit. While the sink stalls, the result holds on the
// master stream and no new request is taken.
module int128_arith_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [263:0] s_axis_tdata, // opcode, operand_a_hi, operand_a_lo, operand_b_hi, operand_b_lo
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata  // value_hi, value_lo, flag, order, zero fill
);

  i128_pkg::ctrl_t ctrl;
  logic [127:0] value;
  logic flag;
  logic [1:0] order;

  i128_seq u_seq (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .ctrl_o(ctrl)
  );

  i128_dp u_dp (
    .clk_i,
    .ctrl_i(ctrl),
    .op_i(s_axis_tdata[2:0]),
    .a_i({s_axis_tdata[66:3], s_axis_tdata[130:67]}),
    .b_i({s_axis_tdata[194:131], s_axis_tdata[258:195]}),
    .value_o(value), .flag_o(flag), .order_o(order)
  );

  assign m_axis_tdata = {5'd0, order, flag, value[63:0], value[127:64]};

  // A request and a result never coexist
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");
  // Accepting a request drops ready next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready) else $error("ready after accept");
  // A stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result dropped");

endmodule
